FILE: rtl/core/bsss_pkg.sv
// shared types, constants and the segment table of the blinking seven-segment scanner
package bsss_pkg;

	localparam int BLINK_PERIOD = 100;
	localparam int BLINK_HALF   = BLINK_PERIOD / 2;
	localparam int CNT_W        = 7;

	localparam logic [4:0] BLANK_INDEX = 5'd16;
	localparam logic [2:0] SEL_MAX     = 3'd4;

	// decimal point codes
	localparam logic [1:0] DOT_SECOND = 2'd0;
	localparam logic [1:0] DOT_THIRD  = 2'd1;
	localparam logic [1:0] DOT_NONE   = 2'd2;
	localparam logic [1:0] DOT_FOURTH = 2'd3;

	localparam logic REG_DOT_POSITION = 1'b0;

	// reciprocals for value / 10000 and digit extraction
	localparam logic [16:0] RECIP_10000 = 17'd107375;
	localparam int          SHIFT_10000 = 30;
	localparam int          SHIFT_DIV   = 23;
	localparam logic [15:0] RECIP_10    = 16'd52429;
	localparam int          SHIFT_10    = 19;

	typedef struct packed {
		logic [1:0] pos;
		logic [4:0] head;
		logic       steady;
		logic       blank;
		logic       dot;
	} tick_ctl_t;

	// 2^23 / 10^(3-pos), rounded up
	function automatic logic [23:0] recip_of(input logic [1:0] pos);
		logic [23:0] r;
		case (pos)
			2'd0: r = 24'd8389;
			2'd1: r = 24'd83887;
			2'd2: r = 24'd838861;
			2'd3: r = 24'd8388608;
			default: r = 24'd8388608;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] seg_of(input logic [4:0] idx);
		logic [7:0] s;
		case (idx)
			5'd0:  s = 8'h3f;
			5'd1:  s = 8'h06;
			5'd2:  s = 8'h5b;
			5'd3:  s = 8'h4f;
			5'd4:  s = 8'h66;
			5'd5:  s = 8'h6d;
			5'd6:  s = 8'h7d;
			5'd7:  s = 8'h07;
			5'd8:  s = 8'h7f;
			5'd9:  s = 8'h6f;
			5'd10: s = 8'h77;
			5'd11: s = 8'h7c;
			5'd12: s = 8'h39;
			5'd13: s = 8'h5e;
			5'd14: s = 8'h73;
			5'd15: s = 8'h40;
			5'd16: s = 8'h00;
			5'd17: s = 8'hc0;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/core/bsss_digit_split.sv
// two-stage decimal split: value mod 10000, then the digit at the scan position
module bsss_digit_split (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid_in,
	input  logic [15:0]           value_in,
	input  bsss_pkg::tick_ctl_t   ctl_in,
	output logic                  valid_out,
	output bsss_pkg::tick_ctl_t   ctl_out,
	output logic [3:0]            digit
);
	import bsss_pkg::*;

	logic [32:0] q_prod;
	logic [2:0]  q;
	logic [15:0] q_scaled;
	logic [15:0] vm_full;

	logic [13:0] vm_s2;
	tick_ctl_t   ctl_s2;
	logic        valid_s2;

	logic [37:0] a_prod;
	logic [13:0] a_s3;
	tick_ctl_t   ctl_s3;
	logic        valid_s3;

	logic [29:0] t_prod;
	logic [9:0]  t;
	logic [13:0] t_scaled;
	logic [13:0] d_full;

	// value mod 10000
	assign q_prod   = {17'd0, value_in} * {16'd0, RECIP_10000};
	assign q        = q_prod[SHIFT_10000 +: 3];
	assign q_scaled = 16'({13'd0, q} * 16'd10000);
	assign vm_full  = value_in - q_scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_in;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vm_s2  <= vm_full[13:0];
			ctl_s2 <= ctl_in;
			a_s3   <= a_prod[SHIFT_DIV +: 14];
			ctl_s3 <= ctl_s2;
		end
	end

	// vm / 10^(3-pos)
	assign a_prod = {24'd0, vm_s2} * {14'd0, recip_of(ctl_s2.pos)};

	// remainder by ten
	assign t_prod   = {16'd0, a_s3} * {14'd0, RECIP_10};
	assign t        = t_prod[SHIFT_10 +: 10];
	assign t_scaled = 14'({4'd0, t} * 14'd10);
	assign d_full   = a_s3 - t_scaled;

	assign digit     = d_full[3:0];
	assign valid_out = valid_s3;
	assign ctl_out   = ctl_s3;

endmodule

FILE: rtl/core/blinking_seven_segment_scanner.sv
// top level of the blinking four-digit seven-segment scanner
//
//   port group   dir  role                        transfer when
//   s_axis_*     in   display tick                s_axis_tvalid & s_axis_tready
//   m_axis_*     out  driven digit and segments   m_axis_tvalid & m_axis_tready
//   apb          in   dot position register       psel & penable & pwrite
//
// one tick per clock while the output is not stalled
// a tick passes the input register, mod 10000 multiply, digit divide and output register
// scan position and blink counter advance on each input transfer
// reset clears the pipeline, scan position and blink counter; dot position resets to none
// a stalled output stalls every stage and holds s_axis_tready low
module blinking_seven_segment_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // value[15:0], head_symbol[20:16], steady_select[23:21]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // digit_enable_n[3:0], segments[11:4], digit_index[13:12]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bsss_pkg::*;

	logic             en;
	logic             accept;
	logic [1:0]       dot_position_q;
	logic [1:0]       scan_q;
	logic [CNT_W-1:0] blink_count_q;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] cnt_next;
	logic [2:0]       sel_in;
	logic [2:0]       sel_eff;
	logic             dot_hit;
	tick_ctl_t        ctl_in;

	logic [15:0]      value_s1;
	tick_ctl_t        ctl_s1;
	logic             valid_s1;

	logic             split_valid;
	tick_ctl_t        split_ctl;
	logic [3:0]       split_digit;
	logic [4:0]       shown;
	logic [7:0]       seg;

	logic             out_valid_q;
	logic [15:0]      out_data_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DOT_POSITION) ? {30'd0, dot_position_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_position_q <= DOT_NONE;
		end else if (psel && penable && pwrite && paddr[2] == REG_DOT_POSITION) begin
			dot_position_q <= pwdata[1:0];
		end
	end

	// tick state
	assign cnt_inc  = blink_count_q + CNT_W'(1);
	assign cnt_next = (cnt_inc >= CNT_W'(BLINK_PERIOD)) ? '0 : cnt_inc;
	assign sel_in   = s_axis_tdata[23:21];
	assign sel_eff  = (sel_in > SEL_MAX) ? 3'd0 : sel_in;

	always_comb begin
		case (scan_q)
			2'd0: dot_hit = 1'b0;
			2'd1: dot_hit = (dot_position_q == DOT_SECOND);
			2'd2: dot_hit = (dot_position_q == DOT_THIRD);
			2'd3: dot_hit = (dot_position_q == DOT_FOURTH);
			default: dot_hit = 1'b0;
		endcase
		ctl_in.pos    = scan_q;
		ctl_in.head   = s_axis_tdata[20:16];
		ctl_in.steady = (sel_eff != 3'd0) && (sel_eff == {1'b0, scan_q} + 3'd1);
		ctl_in.blank  = (cnt_next >= CNT_W'(BLINK_HALF));
		ctl_in.dot    = dot_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q        <= 2'd0;
			blink_count_q <= '0;
		end else if (accept) begin
			scan_q        <= scan_q + 2'd1;
			blink_count_q <= cnt_next;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_s1 <= s_axis_tdata[15:0];
			ctl_s1   <= ctl_in;
		end
	end

	bsss_digit_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (valid_s1),
		.value_in  (value_s1),
		.ctl_in    (ctl_s1),
		.valid_out (split_valid),
		.ctl_out   (split_ctl),
		.digit     (split_digit)
	);

	// segment select
	always_comb begin
		if (split_ctl.steady) begin
			shown = split_ctl.head;
		end else if (split_ctl.blank) begin
			shown = BLANK_INDEX;
		end else begin
			shown = {1'b0, split_digit};
		end
		seg = seg_of(shown) | {split_ctl.dot, 7'd0};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= split_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {2'd0, split_ctl.pos, seg, ~(4'b0001 << split_ctl.pos)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/core/bsss_checker.sv
// port-level assertions for the blinking seven-segment scanner
module bsss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	logic [1:0] last_idx_q;
	logic       seen_q;
	logic       out_xfer;

	assign out_xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q <= 2'd0;
			seen_q     <= 1'b0;
		end else if (out_xfer) begin
			last_idx_q <= m_axis_tdata[13:12];
			seen_q     <= 1'b1;
		end
	end

	// enable low bit matches the driven digit
	a_enable_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($countones(m_axis_tdata[3:0]) == 3) &&
			!m_axis_tdata[m_axis_tdata[13:12]])
		else $error("digit enable does not match digit index");

	// scan order across result transfers
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && seen_q |-> m_axis_tdata[13:12] == last_idx_q + 2'd1)
		else $error("scan position skipped or repeated");

	// input stalls only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind blinking_seven_segment_scanner bsss_checker u_bsss_checker (.*);
